// ===== rtl/notification_queue_with_purge_assert.svh =====
// ----------------------------------------------------------------------------
// Notification queue assertion macros
// Small wrappers for the concurrent checks used in the queue top level.
// ----------------------------------------------------------------------------
`ifndef NOTIFICATION_QUEUE_WITH_PURGE_ASSERT_SVH
`define NOTIFICATION_QUEUE_WITH_PURGE_ASSERT_SVH

// same-cycle implication under async active-low reset
`define NQP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under async active-low reset
`define NQP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/nqp_pkg.sv =====
// ----------------------------------------------------------------------------
// nqp_pkg
// Shared types and codes for the notification queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nqp_pkg;

	localparam int unsigned MODE_W   = 2;
	localparam int unsigned STATUS_W = 3;

	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PURGE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PUSH_EMPTY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POPPED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_A,
		S_POP_B,
		S_PURGE
	} nqp_state_t;

endpackage

`default_nettype wire

// ===== rtl/nqp_ram.sv =====
// ----------------------------------------------------------------------------
// nqp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nqp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/notification_queue_with_purge.sv =====
// ----------------------------------------------------------------------------
// notification_queue_with_purge
// Circular notification FIFO with pop peek and an in-place selective purge.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high, in the cycle after
// the last working cycle, and cannot be held off. Push, full push, empty pop
// and the unused mode finish in the accept cycle (result on the next cycle).
// A pop makes two reads of the single read port of the entry RAM (head,
// then new head). A purge reads one entry per cycle through that read port,
// compacting survivors through the write port behind the read pointer. busy
// is high in every working cycle after the accept cycle and stays low for
// items that finish in the accept cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "notification_queue_with_purge_assert.svh"

module notification_queue_with_purge
	import nqp_pkg::*;
#(
	parameter int DEPTH        = 32,
	parameter int HANDLER_BITS = 16,
	parameter int MASK_BITS    = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [MODE_W-1:0]           mode,
	input  wire logic [HANDLER_BITS-1:0]     in_handler,
	input  wire logic [MASK_BITS-1:0]        in_mask,
	output logic                             done,
	output logic [STATUS_W-1:0]              status,
	output logic [HANDLER_BITS-1:0]          out_handler,
	output logic [MASK_BITS-1:0]             out_mask,
	output logic                             more_queued,
	output logic [HANDLER_BITS-1:0]          next_handler,
	output logic [MASK_BITS-1:0]             next_mask,
	output logic [$clog2(DEPTH+1)-1:0]       purged_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam int DW = HANDLER_BITS + MASK_BITS;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// base + offset modulo DEPTH; offset never exceeds DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	nqp_state_t state_q, state_d;

	logic [AW-1:0]           head_q, head_d;
	logic [CW-1:0]           count_q, count_d;
	logic [CW-1:0]           rd_q, rd_d;
	logic [CW-1:0]           kept_q, kept_d;
	logic [CW-1:0]           purged_q, purged_d;
	logic                    pend_q, pend_d;
	logic [HANDLER_BITS-1:0] hnd_q, hnd_d;
	logic [MASK_BITS-1:0]    msk_q, msk_d;
	logic [DW-1:0]           hold_q, hold_d;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [DW-1:0]           ram_wdata, ram_rdata;
	logic [CW-1:0]           rd_off, wr_off;

	logic                    emit;
	logic [STATUS_W-1:0]     e_status;
	logic [DW-1:0]           e_out, e_next;
	logic                    e_more;
	logic [CW-1:0]           e_purged;

	logic                    done_q;
	logic [STATUS_W-1:0]     status_q;
	logic [DW-1:0]           out_q, next_q;
	logic                    more_q;
	logic [CW-1:0]           purged_out_q;

	logic [HANDLER_BITS-1:0] ent_h;
	logic [MASK_BITS-1:0]    ent_m;
	logic                    ent_match;
	logic                    accept;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign ent_h     = ram_rdata[DW-1:MASK_BITS];
	assign ent_m     = ram_rdata[MASK_BITS-1:0];
	assign ent_match = (ent_h != '0) && ((hnd_q == '0) || (hnd_q == ent_h));
	assign ram_raddr = wrap_add(head_q, rd_off);
	assign ram_waddr = wrap_add(head_q, wr_off);

	nqp_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		rd_d      = rd_q;
		kept_d    = kept_q;
		purged_d  = purged_q;
		pend_d    = pend_q;
		hnd_d     = hnd_q;
		msk_d     = msk_q;
		hold_d    = hold_q;
		ram_we    = 1'b0;
		ram_wdata = {in_handler, in_mask};
		rd_off    = '0;
		wr_off    = count_q;
		emit      = 1'b0;
		e_status  = ST_DONE;
		e_out     = '0;
		e_next    = '0;
		e_more    = 1'b0;
		e_purged  = '0;

		case (state_q)
			S_IDLE: begin
				// read port sits on the head so a pop finds its data registered in S_POP_A
				if (accept) begin
					case (mode)
						MODE_PUSH: begin
							emit = 1'b1;
							if (count_q == FULL_CNT) begin
								e_status = ST_PUSH_FULL;
							end else begin
								ram_we   = 1'b1;
								e_status = (count_q == '0) ? ST_PUSH_EMPTY : ST_DONE;
								count_d  = count_q + 1'b1;
							end
						end
						MODE_POP: begin
							if (count_q == '0) begin
								emit     = 1'b1;
								e_status = ST_POP_EMPTY;
							end else begin
								state_d = S_POP_A;
							end
						end
						MODE_PURGE: begin
							hnd_d    = in_handler;
							msk_d    = in_mask;
							rd_d     = '0;
							kept_d   = '0;
							purged_d = '0;
							pend_d   = 1'b0;
							state_d  = S_PURGE;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_POP_A: begin
				hold_d  = ram_rdata;
				rd_off  = CW'(1);
				state_d = S_POP_B;
			end
			S_POP_B: begin
				emit     = 1'b1;
				e_status = ST_POPPED;
				e_out    = hold_q;
				e_more   = (count_q != CW'(1));
				e_next   = e_more ? ram_rdata : '0;
				head_d   = wrap_add(head_q, CW'(1));
				count_d  = count_q - 1'b1;
				state_d  = S_IDLE;
			end
			S_PURGE: begin
				rd_off    = rd_q;
				wr_off    = kept_q;
				ram_wdata = {ent_h, ent_match ? (ent_m & ~msk_q) : ent_m};
				if (pend_q) begin
					if (ent_match && ((ent_m & ~msk_q) == '0)) begin
						purged_d = purged_q + 1'b1;
					end else begin
						ram_we = 1'b1;
						kept_d = kept_q + 1'b1;
					end
				end
				if (rd_q != count_q) begin
					rd_d   = rd_q + 1'b1;
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
				end
				if (!pend_q && (rd_q == count_q)) begin
					emit     = 1'b1;
					e_purged = purged_q;
					count_d  = kept_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		rd_q     <= rd_d;
		kept_q   <= kept_d;
		purged_q <= purged_d;
		hnd_q    <= hnd_d;
		msk_q    <= msk_d;
		hold_q   <= hold_d;
		if (emit) begin
			status_q     <= e_status;
			out_q        <= e_out;
			next_q       <= e_next;
			more_q       <= e_more;
			purged_out_q <= e_purged;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_handler  = out_q[DW-1:MASK_BITS];
	assign out_mask     = out_q[MASK_BITS-1:0];
	assign more_queued  = more_q;
	assign next_handler = next_q[DW-1:MASK_BITS];
	assign next_mask    = next_q[MASK_BITS-1:0];
	assign purged_count = purged_out_q;

	// on the last entry the read pointer has run past the tail and its data is unused
	`NQP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT,
		"entry count above depth")
	`NQP_ASSERT_IMP(a_purge_no_collide, clk, arst_n,
		(state_q == S_PURGE) && ram_we && (rd_q != count_q), ram_waddr != ram_raddr,
		"purge write hits the slot being read")
	`NQP_ASSERT_NEXT(a_full_refused, clk, arst_n,
		accept && (mode == MODE_PUSH) && (count_q == FULL_CNT),
		done_q && (status_q == ST_PUSH_FULL) && (count_q == FULL_CNT),
		"push into full queue not refused")
	`NQP_ASSERT_NEXT(a_pop_result, clk, arst_n, state_q == S_POP_B,
		done_q && (status_q == ST_POPPED) && (count_q == $past(count_q) - 1'b1),
		"pop did not report and shrink the queue")

endmodule

`default_nettype wire

// ===== tb/notification_queue_with_purge_tb.sv =====
// ----------------------------------------------------------------------------
// notification_queue_with_purge_tb
// Self-checking bench for the notification queue. It drives push, pop, purge
// and unused-mode items through the start/busy handshake, with sender bursts
// and gaps. A scoreboard class keeps its own copy of the queue and predicts
// each result. Every done strobe is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module notification_queue_with_purge_tb;
	import nqp_pkg::*;

	localparam int unsigned DEPTH = 32;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned RAND_ITEMS = 480;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [15:0]         hnd;
		logic [15:0]         msk;
		logic                more;
		logic [15:0]         next_hnd;
		logic [15:0]         next_msk;
		logic [5:0]          purged;
	} notify_result_t;

	class notify_scoreboard;
		logic [15:0]    slot_hnd [DEPTH];
		logic [15:0]    slot_msk [DEPTH];
		int unsigned    head;
		int unsigned    count;
		notify_result_t expected_q[$];
		int unsigned    errors;

		function new();
			head = 0;
			count = 0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// predict the result of an accepted item and update the queue copy
		function void note_input(logic [MODE_W-1:0] op, logic [15:0] h, logic [15:0] m);
			notify_result_t r;
			int unsigned    src;
			int unsigned    dst;
			int unsigned    kept;
			logic [15:0]    eh;
			logic [15:0]    em;
			r.status = ST_DONE;
			r.hnd = '0;
			r.msk = '0;
			r.more = 1'b0;
			r.next_hnd = '0;
			r.next_msk = '0;
			r.purged = '0;
			case (op)
				MODE_PUSH: begin
					if (count >= DEPTH) begin
						r.status = ST_PUSH_FULL;
					end else begin
						dst = (head + count) % DEPTH;
						r.status = (count == 0) ? ST_PUSH_EMPTY : ST_DONE;
						slot_hnd[dst] = h;
						slot_msk[dst] = m;
						count++;
					end
				end
				MODE_POP: begin
					if (count == 0) begin
						r.status = ST_POP_EMPTY;
					end else begin
						r.status = ST_POPPED;
						r.hnd = slot_hnd[head];
						r.msk = slot_msk[head];
						head = (head + 1) % DEPTH;
						count--;
						if (count != 0) begin
							r.more = 1'b1;
							r.next_hnd = slot_hnd[head];
							r.next_msk = slot_msk[head];
						end
					end
				end
				MODE_PURGE: begin
					// compaction in place is safe: dst never runs ahead of src
					kept = 0;
					for (int unsigned i = 0; i < count; i++) begin
						src = (head + i) % DEPTH;
						eh = slot_hnd[src];
						em = slot_msk[src];
						if (eh != 0 && (h == 0 || h == eh)) begin
							if ((em & ~m) == 0) begin
								r.purged++;
								continue;
							end
							em = em & ~m;
						end
						dst = (head + kept) % DEPTH;
						slot_hnd[dst] = eh;
						slot_msk[dst] = em;
						kept++;
					end
					count = kept;
				end
				default: begin
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(notify_result_t got);
			notify_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding: status %0d", got.status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare("status", want.status, got.status);
			compare("out_handler", want.hnd, got.hnd);
			compare("out_mask", want.msk, got.msk);
			compare("more_queued", want.more, got.more);
			compare("next_handler", want.next_hnd, got.next_hnd);
			compare("next_mask", want.next_msk, got.next_msk);
			compare("purged_count", want.purged, got.purged);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [MODE_W-1:0]   mode = MODE_PUSH;
	logic [15:0]         in_handler = '0;
	logic [15:0]         in_mask = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [15:0]         out_handler;
	logic [15:0]         out_mask;
	logic                more_queued;
	logic [15:0]         next_handler;
	logic [15:0]         next_mask;
	logic [5:0]          purged_count;

	notify_scoreboard sb = new();
	notify_result_t   seen;
	int unsigned      burst_left = 0;

	notification_queue_with_purge #(
		.DEPTH(DEPTH),
		.HANDLER_BITS(16),
		.MASK_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.in_handler(in_handler),
		.in_mask(in_mask),
		.done(done),
		.status(status),
		.out_handler(out_handler),
		.out_mask(out_mask),
		.more_queued(more_queued),
		.next_handler(next_handler),
		.next_mask(next_mask),
		.purged_count(purged_count)
	);

	always #10 clk = ~clk;

	// results cannot be held off: take every strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			seen.status = status;
			seen.hnd = out_handler;
			seen.msk = out_mask;
			seen.more = more_queued;
			seen.next_hnd = next_handler;
			seen.next_msk = next_mask;
			seen.purged = purged_count;
			sb.check_result(seen);
		end
	end

	task automatic send_item(input logic [MODE_W-1:0] op, input logic [15:0] h,
			input logic [15:0] m);
		start <= 1'b1;
		mode <= op;
		in_handler <= h;
		in_mask <= m;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_input(op, h, m);
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// sender bursts: random length, occasionally long, random gap after each
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			pause($urandom_range(1, 8));
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_handler();
		case ($urandom_range(0, 9))
			0, 1: return 16'h0000;
			2, 3: return 16'h0001;
			4: return 16'h0002;
			5: return 16'h0003;
			6: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_mask();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001 << $urandom_range(0, 15);
			3: return 16'h000F << (4 * $urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned       sent;
		int unsigned       seg_len;
		int unsigned       kind;
		int unsigned       roll;
		int unsigned       guard;
		logic [MODE_W-1:0] op;
		logic [15:0]       h;
		logic [15:0]       m;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-queue cases, unused mode, field extremes, purge rules
		send_item(MODE_POP, 16'h0000, 16'h0000);
		send_item(MODE_PURGE, 16'h0000, 16'hFFFF);
		send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
		send_item(MODE_PUSH, 16'h0000, 16'hFFFF);
		send_item(MODE_PUSH, 16'hFFFF, 16'h0000);
		send_item(MODE_PUSH, 16'h0005, 16'h00F0);
		send_item(MODE_PUSH, 16'h0005, 16'h0F0F);
		send_item(MODE_PUSH, 16'h0007, 16'h0001);
		send_item(MODE_PURGE, 16'h0005, 16'h00FF);
		send_item(MODE_POP, 16'h0000, 16'h0000);
		// zero purge mask drops only entries whose mask is already zero
		send_item(MODE_PURGE, 16'h0000, 16'h0000);
		send_item(MODE_UNUSED, 16'h0000, 16'h0000);
		send_item(MODE_PUSH, 16'h0000, 16'h0000);
		// general wakeups survive a purge of all handlers
		send_item(MODE_PURGE, 16'h0000, 16'hFFFF);
		send_item(MODE_POP, 16'hFFFF, 16'hFFFF);
		send_item(MODE_POP, 16'h0000, 16'h0000);
		send_item(MODE_PUSH, 16'h0001, 16'hAAAA);
		send_item(MODE_PUSH, 16'h0002, 16'h5555);
		send_item(MODE_PURGE, 16'h0003, 16'hFFFF);
		send_item(MODE_POP, 16'h0000, 16'h0000);
		send_item(MODE_POP, 16'h0000, 16'h0000);
		wait_drained();

		// random: segments biased toward filling, draining or a mix
		sent = 0;
		kind = 0;
		while (sent < RAND_ITEMS) begin
			seg_len = $urandom_range(15, 60);
			for (int unsigned k = 0; k < seg_len && sent < RAND_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				case (kind)
					0: op = (roll < 88) ? MODE_PUSH : (roll < 93) ? MODE_PURGE
						: (roll < 97) ? MODE_POP : MODE_UNUSED;
					1: op = (roll < 75) ? MODE_POP : (roll < 88) ? MODE_PUSH
						: (roll < 97) ? MODE_PURGE : MODE_UNUSED;
					default: op = (roll < 45) ? MODE_PUSH : (roll < 78) ? MODE_POP
						: (roll < 95) ? MODE_PURGE : MODE_UNUSED;
				endcase
				h = pick_handler();
				m = pick_mask();
				if (op == MODE_PURGE && $urandom_range(0, 2) == 0)
					m = m | 16'($urandom);
				send_item(op, h, m);
				sent++;
				pace();
			end
			// hold off now and then until the queue has answered everything
			if ($urandom_range(0, 3) == 0 || sent == seg_len)
				wait_drained();
			kind = $urandom_range(0, 2);
		end

		start <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (sb.pending() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		// margin for a late result, such as a purge of a full queue, which reads every entry
		repeat (40) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
